### sv/ptrk_pkg.sv
// Shared types and constants for the pointer tracker with button edge events.
// Used by ptrk_front, ptrk_fifo, ptrk_back and the top level. No dependencies.
`default_nettype none

package ptrk_pkg;

  // Coordinate width of the stored cursor and of the reported position.
  localparam int COORD_BITS = 12;

  // Extent registers are 13 bits wide.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // Extent compare width: wide enough for the register and for 2^COORD_BITS.
  localparam int EXT_W  = (COORD_BITS + 1 > CFG_W) ? COORD_BITS + 1 : CFG_W;
  // Signed width of the unclamped coordinate.
  localparam int CALC_W = ((EXT_W > 16) ? EXT_W : 16) + 2;

  localparam logic [EXT_W-1:0] EXT_CAP = EXT_W'(1 << COORD_BITS);

  localparam int WIDTH_RESET_INT  = 1024;
  localparam int HEIGHT_RESET_INT = 768;
  localparam int CAP_INT          = 1 << COORD_BITS;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(WIDTH_RESET_INT);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(HEIGHT_RESET_INT);

  // Cursor starts in the middle of the effective reset extent.
  localparam logic [COORD_BITS-1:0] CURSOR_X_RESET =
    COORD_BITS'(((WIDTH_RESET_INT > CAP_INT) ? CAP_INT : WIDTH_RESET_INT) / 2);
  localparam logic [COORD_BITS-1:0] CURSOR_Y_RESET =
    COORD_BITS'(((HEIGHT_RESET_INT > CAP_INT) ? CAP_INT : HEIGHT_RESET_INT) / 2);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

  // Input item kinds.
  localparam logic FUNC_RELATIVE = 1'b0;
  localparam logic FUNC_ABSOLUTE = 1'b1;

  // Button masks and button selectors.
  localparam logic [1:0] BTN_LEFT_MASK  = 2'h1;
  localparam logic [1:0] BTN_RIGHT_MASK = 2'h2;
  localparam logic       BTN_LEFT_SEL   = 1'b0;
  localparam logic       BTN_RIGHT_SEL  = 1'b1;

  typedef enum logic [1:0] {
    EV_MOVE    = 2'd0,
    EV_PRESS   = 2'd1,
    EV_RELEASE = 2'd2
  } ptrk_event_t;

  // Stream widths.
  localparam int S_TDATA_W    = 56;
  localparam int M_DATA_BITS  = 1 + 2 * COORD_BITS;
  localparam int M_TDATA_W    = ((M_DATA_BITS + 7) / 8) * 8;

  // Queue between the front and the back.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // One classified item: new position, which buttons changed and the button state now.
  typedef struct packed {
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic [1:0]            btn_change;
    logic [1:0]            btn_now;
  } ptrk_entry_t;

endpackage

`default_nettype wire

### sv/ptrk_fifo.sv
// Short register queue that carries classified items from the front to the back.
// Depends on ptrk_pkg for the entry type and depth.
`default_nettype none

module ptrk_fifo
  import ptrk_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr_en,
  input  wire ptrk_entry_t wr_data,
  input  wire logic        rd_en,
  output ptrk_entry_t      rd_data,
  output logic             empty,
  output logic             full
);

  ptrk_entry_t             mem [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr;
  logic [FIFO_PTR_W-1:0]   rd_ptr;
  logic [FIFO_PTR_W:0]     count;

  assign empty   = (count == '0);
  assign full    = (count == (FIFO_PTR_W+1)'(FIFO_DEPTH));
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### sv/ptrk_front.sv
// Front part: holds the extent registers and the cursor, accepts input
// transactions, clamps the new position and finds button edges. Uses ptrk_pkg.
`default_nettype none

module ptrk_front
  import ptrk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  func,
  input  wire logic [1:0]            button_bits,
  input  wire logic signed [7:0]     delta_x,
  input  wire logic signed [7:0]     delta_y,
  input  wire logic signed [15:0]    abs_x,
  input  wire logic signed [15:0]    abs_y,
  input  wire logic                  q_full,
  output logic                       q_wr_en,
  output ptrk_entry_t                q_wr_data
);

  logic [CFG_W-1:0]       screen_width;
  logic [CFG_W-1:0]       screen_height;
  logic [COORD_BITS-1:0]  cursor_x;
  logic [COORD_BITS-1:0]  cursor_y;
  logic [1:0]             prev_buttons;

  logic signed [CALC_W-1:0] raw_x;
  logic signed [CALC_W-1:0] raw_y;
  logic [COORD_BITS-1:0]    cursor_x_next;
  logic [COORD_BITS-1:0]    cursor_y_next;

  // Clamp a signed coordinate to 0..extent-1, with extent forced into 1..2^COORD_BITS.
  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [CALC_W-1:0] v,
    input logic [CFG_W-1:0]         extent_reg
  );
    logic [EXT_W-1:0]      ext;
    logic [COORD_BITS-1:0] res;
    ext = EXT_W'(extent_reg);
    if (ext == '0) begin
      ext = EXT_W'(1);
    end
    if (ext > EXT_CAP) begin
      ext = EXT_CAP;
    end
    if (v < 0) begin
      res = '0;
    end else if (v >= CALC_W'($signed({1'b0, ext}))) begin
      res = COORD_BITS'(ext - 1'b1);
    end else begin
      res = COORD_BITS'(v);
    end
    return res;
  endfunction

  assign in_ready = !q_full;
  assign q_wr_en  = in_valid && in_ready;

  always_comb begin
    if (func == FUNC_ABSOLUTE) begin
      raw_x = CALC_W'(abs_x);
      raw_y = CALC_W'(abs_y);
    end else begin
      raw_x = CALC_W'($signed({1'b0, cursor_x})) + CALC_W'(delta_x);
      raw_y = CALC_W'($signed({1'b0, cursor_y})) - CALC_W'(delta_y);
    end
    cursor_x_next = clamp_coord(raw_x, screen_width);
    cursor_y_next = clamp_coord(raw_y, screen_height);
  end

  always_comb begin
    q_wr_data.pos_x      = cursor_x_next;
    q_wr_data.pos_y      = cursor_y_next;
    q_wr_data.btn_change = button_bits ^ prev_buttons;
    q_wr_data.btn_now    = button_bits;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= WIDTH_RESET;
      screen_height <= HEIGHT_RESET;
      cursor_x      <= CURSOR_X_RESET;
      cursor_y      <= CURSOR_Y_RESET;
      prev_buttons  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
          REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        endcase
      end
      if (q_wr_en) begin
        cursor_x     <= cursor_x_next;
        cursor_y     <= cursor_y_next;
        prev_buttons <= button_bits;
      end
    end
  end

endmodule

`default_nettype wire

### sv/ptrk_back.sv
// Back part: walks one queued item through its move and button events and
// holds each event in the output register. Uses ptrk_pkg.
`default_nettype none

module ptrk_back
  import ptrk_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire ptrk_entry_t        q_rd_data,
  input  wire logic               q_empty,
  output logic                    q_rd_en,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output ptrk_event_t             event_kind,
  output logic                    which_button,
  output logic [COORD_BITS-1:0]   pos_x,
  output logic [COORD_BITS-1:0]   pos_y,
  output logic                    last
);

  typedef enum logic [1:0] {
    PH_MOVE,
    PH_LEFT,
    PH_RIGHT
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  ptrk_event_t kind_sel;
  logic        btn_sel;
  logic        last_sel;
  logic        has_left;
  logic        has_right;
  logic        load;

  assign has_left  = |(q_rd_data.btn_change & BTN_LEFT_MASK);
  assign has_right = |(q_rd_data.btn_change & BTN_RIGHT_MASK);
  assign load      = !q_empty && (!out_valid || out_ready);
  assign q_rd_en   = load && last_sel;

  always_comb begin
    kind_sel   = EV_MOVE;
    btn_sel    = BTN_LEFT_SEL;
    last_sel   = 1'b1;
    phase_next = PH_MOVE;
    unique case (phase)
      PH_MOVE: begin
        last_sel = !has_left && !has_right;
        if (has_left) begin
          phase_next = PH_LEFT;
        end else if (has_right) begin
          phase_next = PH_RIGHT;
        end
      end
      PH_LEFT: begin
        kind_sel = |(q_rd_data.btn_now & BTN_LEFT_MASK) ? EV_PRESS : EV_RELEASE;
        last_sel = !has_right;
        if (has_right) begin
          phase_next = PH_RIGHT;
        end
      end
      PH_RIGHT: begin
        kind_sel = |(q_rd_data.btn_now & BTN_RIGHT_MASK) ? EV_PRESS : EV_RELEASE;
        btn_sel  = BTN_RIGHT_SEL;
      end
      default: begin
        phase_next = PH_MOVE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_MOVE;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_kind   <= kind_sel;
      which_button <= btn_sel;
      pos_x        <= q_rd_data.pos_x;
      pos_y        <= q_rd_data.pos_y;
      last         <= last_sel;
    end
  end

endmodule

`default_nettype wire

### sv/pointer_tracker_with_button_edges_top.sv
// Top level of the pointer tracker with button edge events.
// Depends on ptrk_pkg, ptrk_front, ptrk_fifo and ptrk_back.
//
//  Channel  Signals                            Contents (lowest bit first)
//  -------  ---------------------------------  -----------------------------------------
//  input    s_tvalid s_tready s_tdata s_tuser  tdata: button_bits, delta_x, delta_y,
//                                              abs_x, abs_y, zero fill; tuser: func
//  output   m_tvalid m_tready m_tdata m_tuser  tdata: which_button, pos_x, pos_y,
//           m_tlast                            zero fill; tuser: event_kind; tlast: last
//  config   cfg_we cfg_index cfg_data          index 0 screen_width, 1 screen_height
//
// Each mouse report produces one to three output transactions: a move event, then
// a press or release for the left button and for the right button where they changed.
// The output register sends one event per cycle unless m_tready holds it; a report stays
// queued until its last event loads, and that event walk in the back part sets the rate.
// The front part takes a report every cycle while the four-entry queue has room, so
// reports keep flowing in while the output side is stalled. Reset is synchronous and
// restores the extents to 1024 by 768, the cursor to the screen center and the buttons
// to released. Configuration writes take effect at the next report's clamp.
`default_nettype none

module pointer_tracker_with_button_edges_top
  import ptrk_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port.
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,
  // Input stream.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // Fields: button_bits[1:0], delta_x[9:2], delta_y[17:10], abs_x[33:18],
  // abs_y[49:34], zero fill.
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // Fields: func[0].
  input  wire logic                  s_tuser,
  // Output stream.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // Fields: which_button[0], pos_x[COORD_BITS:1], pos_y[2*COORD_BITS:COORD_BITS+1],
  // zero fill.
  output logic [M_TDATA_W-1:0]       m_tdata,
  // Fields: event_kind[1:0].
  output logic [1:0]                 m_tuser,
  output logic                       m_tlast
);

  ptrk_entry_t            q_wr_data;
  ptrk_entry_t            q_rd_data;
  logic                   q_wr_en;
  logic                   q_rd_en;
  logic                   q_empty;
  logic                   q_full;

  ptrk_event_t            event_kind;
  logic                   which_button;
  logic [COORD_BITS-1:0]  pos_x;
  logic [COORD_BITS-1:0]  pos_y;

  // The front clamps the new position and classifies the button changes.
  ptrk_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .func        (s_tuser),
    .button_bits (s_tdata[1:0]),
    .delta_x     ($signed(s_tdata[9:2])),
    .delta_y     ($signed(s_tdata[17:10])),
    .abs_x       ($signed(s_tdata[33:18])),
    .abs_y       ($signed(s_tdata[49:34])),
    .q_full      (q_full),
    .q_wr_en     (q_wr_en),
    .q_wr_data   (q_wr_data)
  );

  // The queue decouples report intake from event delivery.
  ptrk_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .empty   (q_empty),
    .full    (q_full)
  );

  // The back expands each queued report into its events.
  ptrk_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_rd_data    (q_rd_data),
    .q_empty      (q_empty),
    .q_rd_en      (q_rd_en),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .event_kind   (event_kind),
    .which_button (which_button),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .last         (m_tlast)
  );

  assign m_tuser = event_kind;
  assign m_tdata = M_TDATA_W'({pos_y, pos_x, which_button});

endmodule

`default_nettype wire
